// ----- sv/sha1_hash_engine_core_defines.svh -----
// Assertion macros used by the checker file of the SHA-1 engine.
// Each macro takes a label, an antecedent, a consequent and a message.
`ifndef SHA1_HASH_ENGINE_CORE_DEFINES_SVH
`define SHA1_HASH_ENGINE_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SHA1_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SHA1_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/sha1_pkg.sv -----
//------------------------------------------------------------------------------
// SHA-1 engine package
// Shared types, state encoding, command and status structures and constants.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sha1_pkg;

    localparam int unsigned NUM_WORDS  = 5;
    localparam int unsigned NUM_ROUNDS = 80;

    localparam logic [6:0] ROUND_LAST  = 7'(NUM_ROUNDS - 1);
    localparam logic [6:0] ROUND_F2    = 7'd20;
    localparam logic [6:0] ROUND_F3    = 7'd40;
    localparam logic [6:0] ROUND_F4    = 7'd60;
    localparam logic [2:0] WORD_LAST   = 3'(NUM_WORDS - 1);
    localparam logic [5:0] FILL_LAST   = 6'd63;
    localparam logic [5:0] LEN_POS     = 6'd56;
    localparam logic [7:0] PAD_BYTE    = 8'h80;

    localparam logic [31:0] IV0 = 32'h67452301;
    localparam logic [31:0] IV1 = 32'hEFCDAB89;
    localparam logic [31:0] IV2 = 32'h98BADCFE;
    localparam logic [31:0] IV3 = 32'h10325476;
    localparam logic [31:0] IV4 = 32'hC3D2E1F0;

    localparam logic [31:0] K1 = 32'h5A827999;
    localparam logic [31:0] K2 = 32'h6ED9EBA1;
    localparam logic [31:0] K3 = 32'h8F1BBCDC;
    localparam logic [31:0] K4 = 32'hCA62C1D6;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_COMP,
        ST_ADD,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic       push_in;
        logic       push_pad;
        logic       load_work;
        logic       round_en;
        logic       add_chain;
        logic       clear_msg;
        logic [6:0] round;
        logic [2:0] word_sel;
    } t_cmd;

    typedef struct packed {
        logic fill_last;
        logic len_go;
    } t_sts;

endpackage

`default_nettype wire

// ----- sv/sha1_ctrl.sv -----
//------------------------------------------------------------------------------
// SHA-1 controller
// Sequences byte absorption, padding, the 80 rounds and the digest beats.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sha1_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic          i_in_byte,
    input  wire logic          i_in_end,
    input  wire logic          i_out_ready,
    input  wire sha1_pkg::t_sts i_sts,
    output sha1_pkg::t_cmd     o_cmd,
    output logic               o_in_ready,
    output logic               o_out_valid,
    output logic               o_out_last
);

    sha1_pkg::t_state r_state, n_state;
    logic [6:0]       r_round, n_round;
    logic [2:0]       r_idx, n_idx;
    logic             r_fin, n_fin;
    logic             r_done, n_done;
    logic             w_acc_in;
    logic             w_acc_out;

    assign w_acc_in  = i_in_valid && (r_state == sha1_pkg::ST_IDLE);
    assign w_acc_out = i_out_ready && (r_state == sha1_pkg::ST_OUT);

    always_comb begin
        n_state = r_state;
        n_round = r_round;
        n_idx   = r_idx;
        n_fin   = r_fin;
        n_done  = r_done;
        case (r_state)
            sha1_pkg::ST_IDLE: begin
                if (w_acc_in) begin
                    if (i_in_byte && i_sts.fill_last) begin
                        n_state = sha1_pkg::ST_COMP;
                        n_round = '0;
                        n_fin   = i_in_end;
                        n_done  = 1'b0;
                    end else if (i_in_end) begin
                        n_state = sha1_pkg::ST_PAD;
                        n_fin   = 1'b1;
                    end
                end
            end
            sha1_pkg::ST_PAD: begin
                if (i_sts.fill_last) begin
                    n_state = sha1_pkg::ST_COMP;
                    n_round = '0;
                    n_done  = i_sts.len_go;
                end
            end
            sha1_pkg::ST_COMP: begin
                n_round = r_round + 7'd1;
                if (r_round == sha1_pkg::ROUND_LAST) begin
                    n_state = sha1_pkg::ST_ADD;
                end
            end
            sha1_pkg::ST_ADD: begin
                if (r_done) begin
                    n_state = sha1_pkg::ST_OUT;
                    n_idx   = '0;
                end else if (r_fin) begin
                    n_state = sha1_pkg::ST_PAD;
                end else begin
                    n_state = sha1_pkg::ST_IDLE;
                end
            end
            sha1_pkg::ST_OUT: begin
                if (w_acc_out) begin
                    if (r_idx == sha1_pkg::WORD_LAST) begin
                        n_state = sha1_pkg::ST_IDLE;
                        n_fin   = 1'b0;
                        n_done  = 1'b0;
                    end else begin
                        n_idx = r_idx + 3'd1;
                    end
                end
            end
            default: begin
                n_state = sha1_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd           = '0;
        o_cmd.round     = r_round;
        o_cmd.word_sel  = r_idx;
        o_in_ready      = 1'b0;
        o_out_valid     = 1'b0;
        o_out_last      = 1'b0;
        case (r_state)
            sha1_pkg::ST_IDLE: begin
                o_in_ready      = 1'b1;
                o_cmd.push_in   = w_acc_in && i_in_byte;
                o_cmd.load_work = w_acc_in && i_in_byte && i_sts.fill_last;
            end
            sha1_pkg::ST_PAD: begin
                o_cmd.push_pad  = 1'b1;
                o_cmd.load_work = i_sts.fill_last;
            end
            sha1_pkg::ST_COMP: begin
                o_cmd.round_en = 1'b1;
            end
            sha1_pkg::ST_ADD: begin
                o_cmd.add_chain = 1'b1;
            end
            sha1_pkg::ST_OUT: begin
                o_out_valid     = 1'b1;
                o_out_last      = (r_idx == sha1_pkg::WORD_LAST);
                o_cmd.clear_msg = w_acc_out && (r_idx == sha1_pkg::WORD_LAST);
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sha1_pkg::ST_IDLE;
            r_round <= '0;
            r_idx   <= '0;
            r_fin   <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_round <= n_round;
            r_idx   <= n_idx;
            r_fin   <= n_fin;
            r_done  <= n_done;
        end
    end

endmodule

`default_nettype wire

// ----- sv/sha1_dp.sv -----
//------------------------------------------------------------------------------
// SHA-1 datapath
// Block shift register doubling as the message schedule window, round logic,
// chaining words, byte count and pad byte generation.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sha1_dp (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire sha1_pkg::t_cmd i_cmd,
    input  wire logic [7:0]     i_byte,
    output sha1_pkg::t_sts      o_sts,
    output logic [31:0]         o_digest
);

    logic [511:0] r_blk;
    logic [5:0]   r_fill;
    logic [63:0]  r_total;
    logic [31:0]  r_h [sha1_pkg::NUM_WORDS];
    logic [31:0]  r_a, r_b, r_c, r_d, r_e;
    logic         r_pad_first;
    logic         r_len_go;

    logic [63:0]  w_bits;
    logic [5:0]   w_len_sh;
    logic [7:0]   w_pad_byte;
    logic [7:0]   w_push_byte;
    logic         w_push;
    logic [31:0]  w_x;
    logic [31:0]  w_new;
    logic [31:0]  w_f;
    logic [31:0]  w_k;
    logic [31:0]  w_t;

    assign w_bits   = {r_total[60:0], 3'b000};
    assign w_len_sh = {3'd7 - r_fill[2:0], 3'b000};

    always_comb begin
        if (r_pad_first) begin
            w_pad_byte = sha1_pkg::PAD_BYTE;
        end else if ((r_fill < sha1_pkg::LEN_POS) || !r_len_go) begin
            w_pad_byte = 8'h00;
        end else begin
            w_pad_byte = w_bits[w_len_sh +: 8];
        end
    end

    assign w_push      = i_cmd.push_in || i_cmd.push_pad;
    assign w_push_byte = i_cmd.push_in ? i_byte : w_pad_byte;

    assign w_x   = r_blk[95:64] ^ r_blk[255:224] ^ r_blk[447:416] ^ r_blk[511:480];
    assign w_new = {w_x[30:0], w_x[31]};

    always_comb begin
        if (i_cmd.round < sha1_pkg::ROUND_F2) begin
            w_f = (r_b & r_c) | (~r_b & r_d);
            w_k = sha1_pkg::K1;
        end else if (i_cmd.round < sha1_pkg::ROUND_F3) begin
            w_f = r_b ^ r_c ^ r_d;
            w_k = sha1_pkg::K2;
        end else if (i_cmd.round < sha1_pkg::ROUND_F4) begin
            w_f = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
            w_k = sha1_pkg::K3;
        end else begin
            w_f = r_b ^ r_c ^ r_d;
            w_k = sha1_pkg::K4;
        end
    end

    assign w_t = {r_a[26:0], r_a[31:27]} + w_f + r_e + w_k + r_blk[511:480];

    assign o_sts.fill_last = (r_fill == sha1_pkg::FILL_LAST);
    assign o_sts.len_go    = r_len_go;

    always_comb begin
        case (i_cmd.word_sel)
            3'd0:    o_digest = r_h[0];
            3'd1:    o_digest = r_h[1];
            3'd2:    o_digest = r_h[2];
            3'd3:    o_digest = r_h[3];
            3'd4:    o_digest = r_h[4];
            default: o_digest = r_h[0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear_msg) begin
            r_fill      <= '0;
            r_total     <= '0;
            r_pad_first <= 1'b1;
            r_len_go    <= 1'b0;
            r_h[0]      <= sha1_pkg::IV0;
            r_h[1]      <= sha1_pkg::IV1;
            r_h[2]      <= sha1_pkg::IV2;
            r_h[3]      <= sha1_pkg::IV3;
            r_h[4]      <= sha1_pkg::IV4;
        end else begin
            if (w_push) begin
                r_fill <= r_fill + 6'd1;
            end
            if (i_cmd.push_in) begin
                r_total <= r_total + 64'd1;
            end
            if (i_cmd.push_pad) begin
                r_pad_first <= 1'b0;
                if (r_fill < sha1_pkg::LEN_POS) begin
                    r_len_go <= 1'b1;
                end
            end
            if (i_cmd.add_chain) begin
                r_h[0] <= r_h[0] + r_a;
                r_h[1] <= r_h[1] + r_b;
                r_h[2] <= r_h[2] + r_c;
                r_h[3] <= r_h[3] + r_d;
                r_h[4] <= r_h[4] + r_e;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_blk <= {r_blk[503:0], w_push_byte};
        end else if (i_cmd.round_en) begin
            r_blk <= {r_blk[479:0], w_new};
        end
        if (i_cmd.load_work) begin
            r_a <= r_h[0];
            r_b <= r_h[1];
            r_c <= r_h[2];
            r_d <= r_h[3];
            r_e <= r_h[4];
        end else if (i_cmd.round_en) begin
            r_a <= w_t;
            r_b <= r_a;
            r_c <= {r_b[1:0], r_b[31:2]};
            r_d <= r_c;
            r_e <= r_d;
        end
    end

endmodule

`default_nettype wire

// ----- sv/sha1_hash_engine_core.sv -----
//------------------------------------------------------------------------------
// SHA-1 hash engine, top level
// Byte-stream SHA-1 with a five-beat digest output.
//------------------------------------------------------------------------------
// The beat that completes a 64-byte block starts the compression, one round per
// cycle through a single round unit, so the input is held off through the 80
// rounds and one chaining update. An end-of-message beat then appends the pad
// and length one byte per cycle, 9 to 72 pad bytes with one or two further
// compressions, and offers the five digest words, most significant first, each
// beat carrying its position; the engine takes no new input until the fifth
// word is accepted, after which it is ready for the next message.
`timescale 1ns / 1ps
`default_nettype none

module sha1_hash_engine_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  wire logic        i_s_axis_tuser,   // [0] byte_present
    input  wire logic        i_s_axis_tlast,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [39:0]      o_m_axis_tdata,   // [31:0] digest_word, [34:32] word_index
    output logic             o_m_axis_tlast
);

    sha1_pkg::t_cmd w_cmd;
    sha1_pkg::t_sts w_sts;
    logic [31:0]    w_digest;

    sha1_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .i_in_byte   (i_s_axis_tuser),
        .i_in_end    (i_s_axis_tlast),
        .i_out_ready (i_m_axis_tready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_out_last  (o_m_axis_tlast)
    );

    sha1_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_byte   (i_s_axis_tdata),
        .o_sts    (w_sts),
        .o_digest (w_digest)
    );

    assign o_m_axis_tdata = {5'b00000, w_cmd.word_sel, w_digest};

endmodule

`default_nettype wire

// ----- sv/sha1_checker.sv -----
//------------------------------------------------------------------------------
// SHA-1 engine port checker
// Watches the stream ports of the engine and is bound to the top level.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "sha1_hash_engine_core_defines.svh"

module sha1_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_s_axis_tvalid,
    input wire logic        o_s_axis_tready,
    input wire logic [7:0]  i_s_axis_tdata,
    input wire logic        i_s_axis_tuser,
    input wire logic        i_s_axis_tlast,
    input wire logic        o_m_axis_tvalid,
    input wire logic        i_m_axis_tready,
    input wire logic [39:0] o_m_axis_tdata,
    input wire logic        o_m_axis_tlast
);

    logic w_unused;

    assign w_unused = ^{i_s_axis_tvalid, i_s_axis_tdata, i_s_axis_tuser, i_s_axis_tlast};

    // The digest is never offered while the engine is open for input.
    `SHA1_ASSERT_SAME(a_no_overlap, o_m_axis_tvalid, !o_s_axis_tready, "ready during digest")

    // The final flag marks exactly the fifth word.
    `SHA1_ASSERT_SAME(a_last_idx, o_m_axis_tvalid, (o_m_axis_tlast == (o_m_axis_tdata[34:32] == 3'd4)), "tlast and index disagree")

    // An accepted word that is not the last is followed at once by the next.
    `SHA1_ASSERT_NEXT(a_idx_step, o_m_axis_tvalid && i_m_axis_tready && !o_m_axis_tlast, o_m_axis_tvalid && (o_m_axis_tdata[34:32] == ($past(o_m_axis_tdata[34:32]) + 3'd1)), "index did not advance")

    // A stalled digest beat holds.
    `SHA1_ASSERT_NEXT(a_out_hold, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata), "stalled beat changed")

endmodule

bind sha1_hash_engine_core sha1_checker u_sha1_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tdata  (i_s_axis_tdata),
    .i_s_axis_tuser  (i_s_axis_tuser),
    .i_s_axis_tlast  (i_s_axis_tlast),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast)
);

`default_nettype wire

// ----- sim/tb_top.sv -----
//------------------------------------------------------------------------------
// Testbench for the byte-stream SHA-1 engine
// Message bytes are streamed in with random bursts and gaps, while the digest
// receiver stalls on its own pattern. Each accepted byte beat also feeds a
// SHA-1 model kept here, and each digest beat is checked against it, with
// published digests used for the empty message and for "abc".
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    localparam int RANDOM_ITEMS = 250;
    localparam int HOLD_CYCLES  = 500;
    localparam int DRAIN_CYCLES = 300;
    localparam int TIMEOUT_NS   = 2_000_000;

    localparam logic [31:0] SHA_H0 = 32'h67452301;
    localparam logic [31:0] SHA_H1 = 32'hEFCDAB89;
    localparam logic [31:0] SHA_H2 = 32'h98BADCFE;
    localparam logic [31:0] SHA_H3 = 32'h10325476;
    localparam logic [31:0] SHA_H4 = 32'hC3D2E1F0;
    localparam logic [31:0] SHA_K1 = 32'h5A827999;
    localparam logic [31:0] SHA_K2 = 32'h6ED9EBA1;
    localparam logic [31:0] SHA_K3 = 32'h8F1BBCDC;
    localparam logic [31:0] SHA_K4 = 32'hCA62C1D6;
    localparam logic [7:0]  SHA_PAD     = 8'h80;
    localparam logic [5:0]  SHA_LEN_POS = 6'd56;

    localparam logic [159:0] DIGEST_EMPTY =
        160'hda39a3ee_5e6b4b0d_3255bfef_95601890_afd80709;
    localparam logic [159:0] DIGEST_ABC =
        160'ha9993e36_4706816a_ba3e2571_7850c26c_9cd0d89d;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } t_digest_beat;

    typedef struct packed {
        logic [7:0]   data;
        logic         present;
        logic         eom;
        logic         known;
        logic [159:0] digest;
    } t_byte_row;

    typedef enum logic [1:0] {
        RX_FLOW,
        RX_RANDOM,
        RX_SPARSE
    } t_rx_pattern;

    localparam int NUM_ROWS = 18;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata;    // [7:0] data_byte
    logic        i_s_axis_tuser;    // [0] byte_present
    logic        i_s_axis_tlast;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [39:0] o_m_axis_tdata;    // [31:0] digest_word, [34:32] word_index
    logic        o_m_axis_tlast;

    logic         item_known;
    logic [159:0] item_digest;

    logic [31:0] sha_chain [5];
    logic [7:0]  sha_block [64];
    logic [5:0]  sha_fill;
    logic [63:0] sha_bytes;

    t_digest_beat expected_digest [$];
    t_byte_row    byte_rows [NUM_ROWS];

    int          error_count    = 0;
    int          messages_done  = 0;
    int          beats_in       = 0;
    int          ignored_in     = 0;
    int          beats_checked  = 0;
    int          longest_msg    = 0;
    int          burst_left     = 0;
    int          rx_left        = 0;
    t_rx_pattern rx_pattern     = RX_FLOW;
    logic        hold_off       = 1'b0;
    logic        random_phase   = 1'b0;

    sha1_hash_engine_core u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic logic [31:0] rol32(input logic [31:0] v, input int unsigned s);
        return (v << s) | (v >> (32 - s));
    endfunction

    task automatic sha1_restart();
        sha_chain[0] = SHA_H0;
        sha_chain[1] = SHA_H1;
        sha_chain[2] = SHA_H2;
        sha_chain[3] = SHA_H3;
        sha_chain[4] = SHA_H4;
        for (int i = 0; i < 64; i++) sha_block[i] = 8'h00;
        sha_fill  = '0;
        sha_bytes = '0;
    endtask

    task automatic sha1_compress();
        logic [31:0] w [80];
        logic [31:0] a, b, c, d, e, f, k, t;
        for (int r = 0; r < 16; r++) begin
            w[r] = {sha_block[4*r], sha_block[4*r+1], sha_block[4*r+2], sha_block[4*r+3]};
        end
        for (int r = 16; r < 80; r++) begin
            w[r] = rol32(w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16], 1);
        end
        a = sha_chain[0];
        b = sha_chain[1];
        c = sha_chain[2];
        d = sha_chain[3];
        e = sha_chain[4];
        for (int r = 0; r < 80; r++) begin
            if (r < 20) begin
                f = (b & c) | (~b & d);
                k = SHA_K1;
            end else if (r < 40) begin
                f = b ^ c ^ d;
                k = SHA_K2;
            end else if (r < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = SHA_K3;
            end else begin
                f = b ^ c ^ d;
                k = SHA_K4;
            end
            t = rol32(a, 5) + f + e + k + w[r];
            e = d;
            d = c;
            c = rol32(b, 30);
            b = a;
            a = t;
        end
        sha_chain[0] += a;
        sha_chain[1] += b;
        sha_chain[2] += c;
        sha_chain[3] += d;
        sha_chain[4] += e;
    endtask

    task automatic sha1_push(input logic [7:0] v);
        sha_block[sha_fill] = v;
        sha_fill = sha_fill + 6'd1;
        if (sha_fill == 6'd0) sha1_compress();
    endtask

    // Absorbs one accepted beat; an end of message queues the five digest words.
    task automatic sha1_absorb(input logic [7:0] b, input logic p, input logic e,
                               input logic k, input logic [159:0] published);
        logic [63:0]  bit_len;
        logic [159:0] dg;
        t_digest_beat beat;
        if (p) begin
            sha1_push(b);
            sha_bytes = sha_bytes + 64'd1;
        end
        if (e) begin
            bit_len = sha_bytes << 3;
            if (sha_bytes > longest_msg) longest_msg = int'(sha_bytes);
            sha1_push(SHA_PAD);
            while (sha_fill != SHA_LEN_POS) sha1_push(8'h00);
            for (int i = 0; i < 8; i++) sha1_push(bit_len[63 - 8*i -: 8]);
            dg = k ? published
                   : {sha_chain[0], sha_chain[1], sha_chain[2], sha_chain[3], sha_chain[4]};
            for (int i = 0; i < 5; i++) begin
                beat.word  = dg[159 - 32*i -: 32];
                beat.index = 3'(i);
                beat.last  = (i == 4);
                expected_digest.push_back(beat);
            end
            sha1_restart();
            messages_done++;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [39:0] got,
                                   input logic [39:0] want);
        $display("MISMATCH at %0t: %s got %h expected %h", $realtime, what, got, want);
        error_count++;
    endtask

    task automatic check_digest_beat(input logic [39:0] data, input logic last);
        t_digest_beat want;
        beats_checked++;
        if (expected_digest.size() == 0) begin
            report_mismatch("digest beat with nothing expected", data, '0);
        end else begin
            want = expected_digest.pop_front();
            if (data[31:0] !== want.word)
                report_mismatch("digest_word", 40'(data[31:0]), 40'(want.word));
            if (data[34:32] !== want.index)
                report_mismatch("word_index", 40'(data[34:32]), 40'(want.index));
            if (data[39:35] !== 5'd0)
                report_mismatch("tdata fill bits", 40'(data[39:35]), '0);
            if (last !== want.last)
                report_mismatch("last_word", 40'(last), 40'(want.last));
        end
    endtask

    task automatic send_item(input logic [7:0] b, input logic p, input logic e,
                             input logic k, input logic [159:0] published);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 8);
        end
        burst_left--;
        @(negedge i_clk);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            i_s_axis_tdata  <= 8'($urandom);
            i_s_axis_tuser  <= 1'($urandom);
            i_s_axis_tlast  <= 1'($urandom);
            repeat (gap) @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= b;
        i_s_axis_tuser  <= p;
        i_s_axis_tlast  <= e;
        item_known      <= k;
        item_digest     <= published;
        do @(posedge i_clk); while (o_s_axis_tready !== 1'b1);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready) begin
            beats_in++;
            if (!i_s_axis_tuser && !i_s_axis_tlast) ignored_in++;
            sha1_absorb(i_s_axis_tdata, i_s_axis_tuser, i_s_axis_tlast,
                        item_known, item_digest);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            check_digest_beat(o_m_axis_tdata, o_m_axis_tlast);
        end
    end

    always @(negedge i_clk) begin
        logic rdy;
        if (rx_left == 0) begin
            rx_pattern = t_rx_pattern'($urandom_range(0, 2));
            rx_left    = $urandom_range(10, 150);
        end
        rx_left--;
        case (rx_pattern)
            RX_FLOW:   rdy = 1'b1;
            RX_RANDOM: rdy = 1'($urandom);
            default:   rdy = ($urandom_range(0, 3) == 0);
        endcase
        i_m_axis_tready <= rdy && !hold_off;
    end

    // Once digests flow in the random phase, the receiver stops for a long
    // stretch so that the engine fills up and holds off the byte stream.
    initial begin : long_hold
        wait (random_phase);
        do @(posedge i_clk); while (o_m_axis_tvalid !== 1'b1);
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off = 1'b0;
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("Timeout at %0t with %0d digest words outstanding",
                 $realtime, expected_digest.size());
        $display("Some tests failed");
        $finish;
    end

    initial begin : stimulus
        int len;
        int done;
        logic tail_byte;
        logic last;

        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = 8'h00;
        i_s_axis_tuser  = 1'b0;
        i_s_axis_tlast  = 1'b0;
        item_known      = 1'b0;
        item_digest     = '0;
        sha1_restart();

        byte_rows = '{
            {8'h00, 1'b0, 1'b1, 1'b1, DIGEST_EMPTY},
            {8'h61, 1'b1, 1'b0, 1'b0, 160'd0},
            {8'h62, 1'b1, 1'b0, 1'b0, 160'd0},
            {8'h63, 1'b1, 1'b1, 1'b1, DIGEST_ABC},
            {8'hFF, 1'b0, 1'b0, 1'b0, 160'd0},
            {8'hA5, 1'b0, 1'b1, 1'b1, DIGEST_EMPTY},
            {8'h00, 1'b1, 1'b0, 1'b0, 160'd0},
            {8'hFF, 1'b1, 1'b0, 1'b0, 160'd0},
            {8'h80, 1'b1, 1'b0, 1'b0, 160'd0},
            {8'h7F, 1'b1, 1'b0, 1'b0, 160'd0},
            {8'hFF, 1'b0, 1'b0, 1'b0, 160'd0},
            {8'h01, 1'b1, 1'b0, 1'b0, 160'd0},
            {8'hFE, 1'b1, 1'b1, 1'b0, 160'd0},
            {8'h00, 1'b1, 1'b1, 1'b0, 160'd0},
            {8'hFF, 1'b1, 1'b1, 1'b0, 160'd0},
            {8'h55, 1'b1, 1'b0, 1'b0, 160'd0},
            {8'hAA, 1'b1, 1'b0, 1'b0, 160'd0},
            {8'hC3, 1'b0, 1'b1, 1'b0, 160'd0}
        };

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < NUM_ROWS; i++) begin
            send_item(byte_rows[i].data, byte_rows[i].present, byte_rows[i].eom,
                      byte_rows[i].known, byte_rows[i].digest);
        end

        random_phase = 1'b1;
        done = 0;
        while (done < RANDOM_ITEMS) begin
            if ($urandom_range(0, 4) == 0) begin
                case ($urandom_range(0, 9))
                    0:       len = 55;
                    1:       len = 56;
                    2:       len = 57;
                    3:       len = 63;
                    4:       len = 64;
                    5:       len = 65;
                    6:       len = 119;
                    7:       len = 120;
                    8:       len = 127;
                    default: len = 128;
                endcase
            end else begin
                len = $urandom_range(0, 12);
            end
            tail_byte = (len > 0) && ($urandom_range(0, 1) == 1);
            for (int i = 0; i < len; i++) begin
                if ($urandom_range(0, 19) == 0) begin
                    send_item(8'($urandom), 1'b0, 1'b0, 1'b0, '0);
                end
                last = tail_byte && (i == len - 1);
                send_item(8'($urandom), 1'b1, last, 1'b0, '0);
                done++;
            end
            if (!tail_byte) begin
                send_item(8'($urandom), 1'b0, 1'b1, 1'b0, '0);
                done++;
            end
        end
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;

        while (expected_digest.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Hashed %0d messages (longest %0d bytes) from %0d input beats, %0d ignored.",
                 messages_done, longest_msg, beats_in, ignored_in);
        $display("Checked %0d digest beats, with a %0d-cycle receiver hold-off on the way.",
                 beats_checked, HOLD_CYCLES);
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
